[rtl/sha256_stream_hasher_macros.svh]
// Assertion macros for the SHA-256 stream hasher checker.
// Plain text only; no dependencies.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHASH_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shash assertion failed");

// Next-cycle implication, disabled during reset.
`define SHASH_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shash assertion failed");

`endif

[rtl/shash_pkg.sv]
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies.
package shash_pkg;

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] RND_LAST   = 6'd63;
    localparam logic [2:0] OUT_LAST   = 3'd7;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    // Sequencer controls to the schedule and round units.
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       shift_word;
        logic       start;
        logic       round;
        logic       fold;
        logic       init;
        logic [5:0] rnd;
    } t_ctl;

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

[rtl/shash_sched.sv]
// Block buffer and message schedule: 16-word shift line, loaded a byte at a
// time, then shifted a word per round. Depends on shash_pkg.
module shash_sched
    import shash_pkg::*;
(
    input  logic        i_clk,
    input  t_ctl        i_ctl,
    output logic [31:0] o_w
);

    logic [511:0] r_blk;
    logic [31:0]  w_new;

    // Word 0 (oldest) sits at the top; taps at words 1, 9 and 14.
    assign o_w   = r_blk[511:480];
    assign w_new = f_ssig1(r_blk[63:32]) + r_blk[223:192]
                 + f_ssig0(r_blk[479:448]) + r_blk[511:480];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_byte) begin
            r_blk <= {r_blk[503:0], i_ctl.byte_val};
        end else if (i_ctl.shift_word) begin
            r_blk <= {r_blk[479:0], w_new};
        end
    end

endmodule

[rtl/shash_round.sv]
// Compression round unit: working variables a..h, one round per cycle,
// and the eight chaining hash words. Depends on shash_pkg.
module shash_round
    import shash_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  logic [31:0] i_w,
    input  logic [2:0]  i_sel,
    output logic [31:0] o_hash
);

    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        t1 = r_v[7] + f_bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
           + K_TAB[i_ctl.rnd] + i_w;
        t2 = f_bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    assign o_hash = r_h[i_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctl.round) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

endmodule

[rtl/sha256_stream_hasher.sv]
// Byte-serial SHA-256: each byte transaction shifts one byte into the block; the 64th byte
// of a block starts the rounds and then the fold (one round per cycle in the round unit).
// Finish: pad bytes to the end of the block, rounds and fold, repeated for a second block
// when the length spills into it, then 8 digest words, one per output transaction.
// Synchronous active-low reset: idle, empty message, hash words at the initial values.
// Depends on shash_pkg, shash_sched, shash_round.
module sha256_stream_hasher
    import shash_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_byte_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last
);

    t_state      r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [63:0] r_len, n_len;
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_mark, n_mark;
    logic        r_lenblk, n_lenblk;
    logic        r_fin, n_fin;
    t_ctl        ctl;
    logic [31:0] w_cur;
    logic [7:0]  len_byte;
    logic [7:0]  pad_byte;

    // Length goes out big-endian in bytes 56..63 of the final block.
    assign len_byte = r_len[{~r_fill[2:0], 3'b000} +: 8];
    assign pad_byte = r_mark ? PAD_MARK :
                      ((r_lenblk && (r_fill >= LEN_OFFSET)) ? len_byte : 8'h00);

    always_comb begin
        n_state  = r_state;
        n_fill   = r_fill;
        n_bits   = r_bits;
        n_len    = r_len;
        n_rnd    = r_rnd;
        n_oidx   = r_oidx;
        n_mark   = r_mark;
        n_lenblk = r_lenblk;
        n_fin    = r_fin;
        ctl      = '0;
        ctl.rnd  = r_rnd;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (!i_kind) begin
                        ctl.shift_byte = 1'b1;
                        ctl.byte_val   = i_byte_value;
                        n_fill = r_fill + 6'd1;
                        n_bits = r_bits + BITS_PER_BYTE;
                        if (r_fill == FILL_LAST) begin
                            ctl.start = 1'b1;
                            n_rnd     = '0;
                            n_state   = ST_ROUND;
                        end
                    end else begin
                        n_mark   = 1'b1;
                        n_lenblk = (r_fill < LEN_OFFSET);
                        n_len    = r_bits;
                        n_fin    = 1'b1;
                        n_state  = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ctl.shift_byte = 1'b1;
                ctl.byte_val   = pad_byte;
                n_mark = 1'b0;
                n_fill = r_fill + 6'd1;
                if (r_fill == FILL_LAST) begin
                    ctl.start = 1'b1;
                    n_rnd     = '0;
                    n_state   = ST_ROUND;
                end
            end
            ST_ROUND: begin
                ctl.round      = 1'b1;
                ctl.shift_word = 1'b1;
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == RND_LAST) begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                ctl.fold = 1'b1;
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_lenblk) begin
                    n_oidx  = '0;
                    n_state = ST_OUT;
                end else begin
                    // padding overflowed: length goes into a second block
                    n_lenblk = 1'b1;
                    n_state  = ST_PAD;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == OUT_LAST) begin
                        ctl.init = 1'b1;
                        n_fill   = '0;
                        n_bits   = '0;
                        n_fin    = 1'b0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_rnd    <= '0;
            r_oidx   <= '0;
            r_mark   <= 1'b0;
            r_lenblk <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_fill   <= n_fill;
            r_bits   <= n_bits;
            r_rnd    <= n_rnd;
            r_oidx   <= n_oidx;
            r_mark   <= n_mark;
            r_lenblk <= n_lenblk;
            r_fin    <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

    shash_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .o_w   (w_cur)
    );

    shash_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_w     (w_cur),
        .i_sel   (r_oidx),
        .o_hash  (o_digest_word)
    );

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = (r_state == ST_OUT);
    assign o_word_index = r_oidx;
    assign o_last       = (r_oidx == OUT_LAST);

endmodule

[rtl/shash_checker.sv]
// Port-level checker for sha256_stream_hasher, attached by bind.
// Depends on sha256_stream_hasher_macros.svh.
`include "sha256_stream_hasher_macros.svh"

module shash_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_kind,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_word_index,
    input logic        o_last
);

    // last marks word 7 and only word 7
    `SHASH_ASSERT_IMP(a_last_idx, i_clk, i_rst_n, o_valid, o_last == (o_word_index == 3'd7))
    // no input transaction while the digest drains
    `SHASH_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_valid, o_stall)
    // a finish transaction makes the block busy
    `SHASH_ASSERT_NXT(a_fin_busy, i_clk, i_rst_n, i_valid && !o_stall && i_kind, o_stall)
    // digest words come in order without gaps
    `SHASH_ASSERT_NXT(a_idx_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_valid && (o_word_index == $past(o_word_index) + 3'd1))
    // exactly eight words: output ends after the last one
    `SHASH_ASSERT_NXT(a_end_out, i_clk, i_rst_n, o_valid && !i_stall && o_last, !o_valid && !o_stall)

endmodule

bind sha256_stream_hasher shash_checker u_shash_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_kind       (i_kind),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_word_index (o_word_index),
    .o_last       (o_last)
);
